/* hw/rtl/hbm_pkg.sv */
package hbm_pkg;

  localparam int SW = 16;
  localparam int PW = 17;
  localparam int DW = 17;
  localparam int BW = 5;
  localparam int KW = SW + BW;
  localparam logic [DW-1:0] DIST_INF = '1;

  localparam logic CMD_SOLVE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_QRD, S_QOUT, S_CLR,
    S_BI_RD, S_BI_WR, S_BQ, S_BQ_U, S_BQ_D, S_BN, S_BN_P, S_BN_D,
    S_DO_RD, S_DO_CK, S_D_DU, S_D_TOP, S_D_POP, S_D_PV, S_D_MD,
    S_AUG1, S_AUG2, S_AUG_LD, S_CN_RD, S_CN_CK, S_DONE
  } st_t;

  typedef struct packed {
    st_t  op;
    logic accept;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic clr_end;
    logic s_end;
    logic s_ev;
    logic q_more;
    logic found;
    logic b_end;
    logic v_bad;
    logic p_match;
    logic mu_inf;
    logic mu_next;
    logic sp_last;
    logic sp_zero;
    logic k_last;
  } stat_t;

  function automatic logic [4:0] popcnt(input logic [SW-1:0] x);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < SW; i++) c = c + 5'(x[i]);
    return c;
  endfunction

endpackage

/* hw/rtl/hbm_ram.sv */
module hbm_ram #(
  parameter int W = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/hbm_ctrl.sv */
module hbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  input  hbm_pkg::stat_t    st,
  output hbm_pkg::ctrl_cmd_t cmd
);
  import hbm_pkg::*;

  st_t state, state_next;
  logic acc;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    in_stall = state != S_IDLE;
    acc = in_valid && !in_stall;
    cmd.op = state;
    cmd.accept = acc;
    state_next = state;
    case (state)
      S_IDLE:   if (acc) state_next = (in_cmd == CMD_QUERY) ? S_QRD : S_CLR;
      S_QRD:    state_next = S_QOUT;
      S_QOUT:   if (!st.out_busy) state_next = S_IDLE;
      S_CLR:    if (st.clr_end) state_next = S_BI_RD;
      S_BI_RD:  if (st.s_end) state_next = S_BQ;
                else if (st.s_ev) state_next = S_BI_WR;
      S_BI_WR:  state_next = S_BI_RD;
      S_BQ:     if (st.q_more) state_next = S_BQ_U;
                else state_next = st.found ? S_DO_RD : S_CN_RD;
      S_BQ_U:   state_next = S_BQ_D;
      S_BQ_D:   state_next = S_BN;
      S_BN:     if (st.b_end) state_next = S_BQ;
                else if (!st.v_bad) state_next = S_BN_P;
      S_BN_P:   state_next = st.p_match ? S_BN_D : S_BN;
      S_BN_D:   state_next = S_BN;
      S_DO_RD:  if (st.s_end) state_next = S_BI_RD;
                else if (st.s_ev) state_next = S_DO_CK;
      S_DO_CK:  state_next = st.p_match ? S_DO_RD : S_D_DU;
      S_D_DU:   state_next = S_D_TOP;
      S_D_TOP:  if (st.b_end) state_next = st.sp_last ? S_DO_RD : S_D_POP;
                else if (!st.v_bad) state_next = S_D_PV;
      S_D_POP:  state_next = S_D_DU;
      S_D_PV:   state_next = st.p_match ? S_D_MD : S_AUG1;
      S_D_MD:   state_next = S_D_TOP;
      S_AUG1:   state_next = S_AUG2;
      S_AUG2:   state_next = st.k_last ? S_DO_RD : S_AUG_LD;
      S_AUG_LD: state_next = S_AUG1;
      S_CN_RD:  if (st.s_end) state_next = S_DONE;
                else if (st.s_ev) state_next = S_CN_CK;
      S_CN_CK:  state_next = S_CN_RD;
      S_DONE:   if (!st.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_QOUT || state == S_DONE) && st.out_busy) |=> state == $past(state))
    else $error("result loaded over a pending result");
  a_query_path: assert property (@(posedge clk) disable iff (rst)
    (acc && in_cmd == CMD_QUERY) |=> state == S_QRD ##1 state == S_QOUT)
    else $error("query did not take the read path");
  a_stack_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_TOP) |-> !st.sp_zero)
    else $error("stack top examined with empty stack");
endmodule

/* hw/rtl/hbm_datapath.sv */
module hbm_datapath #(
  parameter int MAX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  hbm_pkg::ctrl_cmd_t cmd,
  output hbm_pkg::stat_t     st,
  input  logic [4:0]         num_bulbs,
  input  logic [4:0]         max_on,
  input  logic [15:0]        query_state,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [15:0]        partner_state,
  output logic               has_move,
  output logic [15:0]        match_size
);
  import hbm_pkg::*;

  localparam int AW = MAX_BITS;
  localparam int HALF = (2**MAX_BITS + 1) / 2;
  localparam int QAW = (MAX_BITS > 1) ? MAX_BITS - 1 : 1;
  localparam int CW = QAW + 1;
  localparam logic [16:0] LAST = 17'(2**MAX_BITS - 1);

  logic [4:0] m;
  logic [16:0] total, s;
  logic [SW-1:0] q, u, mu, eu, v, vv;
  logic [BW-1:0] b, eb;
  logic [DW-1:0] du;
  logic [CW-1:0] head, tail, sp, k;
  logic [CW-1:0] sp_m2, k_m2;
  logic found, solved;
  logic [15:0] cnt, pcount;
  logic pm, q_room;
  logic [4:0] pc_s;

  logic p_we, d_we, q_we, k_we;
  logic [AW-1:0] p_wa, p_ra, d_wa, d_ra;
  logic [PW-1:0] p_wd, p_rd;
  logic [DW-1:0] d_wd, d_rd;
  logic [QAW-1:0] q_wa, q_ra, k_wa, k_ra;
  logic [SW-1:0] q_wd, q_rd;
  logic [KW-1:0] k_wd, k_rd;

  hbm_ram #(.W(PW), .AW(AW)) u_partner (.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd),
    .raddr(p_ra), .rdata(p_rd));
  hbm_ram #(.W(DW), .AW(AW)) u_dist (.clk, .we(d_we), .waddr(d_wa), .wdata(d_wd),
    .raddr(d_ra), .rdata(d_rd));
  hbm_ram #(.W(SW), .AW(QAW)) u_queue (.clk, .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rd));
  hbm_ram #(.W(KW), .AW(QAW)) u_stack (.clk, .we(k_we), .waddr(k_wa), .wdata(k_wd),
    .raddr(k_ra), .rdata(k_rd));

  always_comb begin
    m = (num_bulbs > 5'(MAX_BITS)) ? 5'(MAX_BITS) : num_bulbs;
    total = 17'(1) << m;
    v = u ^ (SW'(1) << b);
    vv = eu ^ (SW'(1) << eb);
    pc_s = popcnt(s[SW-1:0]);
    pm = p_rd[PW-1];
    q_room = tail < CW'(HALF);
    sp_m2 = sp - CW'(2);
    k_m2 = k - CW'(2);

    st.out_busy = out_valid && out_stall;
    st.clr_end = s == LAST;
    st.s_end = s >= total;
    st.s_ev = pc_s <= max_on && !pc_s[0];
    st.q_more = head < tail;
    st.found = found;
    st.b_end = b >= m;
    st.v_bad = popcnt(v) > max_on;
    st.p_match = pm;
    st.mu_inf = d_rd == DIST_INF;
    st.mu_next = d_rd == du + DW'(1) && sp < CW'(HALF);
    st.sp_last = sp == CW'(1);
    st.sp_zero = sp == '0;
    st.k_last = k == CW'(1);

    p_we = 1'b0; p_wa = s[AW-1:0]; p_wd = '0; p_ra = s[AW-1:0];
    d_we = 1'b0; d_wa = s[AW-1:0]; d_wd = '0; d_ra = s[AW-1:0];
    q_we = 1'b0; q_wa = tail[QAW-1:0]; q_wd = s[SW-1:0]; q_ra = head[QAW-1:0];
    k_we = 1'b0; k_wa = sp_m2[QAW-1:0] + QAW'(1); k_wd = {b, u}; k_ra = sp_m2[QAW-1:0];
    case (cmd.op)
      S_QRD, S_QOUT: p_ra = q[AW-1:0];
      S_CLR: p_we = 1'b1;
      S_BI_WR: begin
        d_we = 1'b1;
        d_wd = pm ? DIST_INF : '0;
        q_we = !pm && q_room;
      end
      S_BQ_U: d_ra = q_rd[AW-1:0];
      S_BN: p_ra = v[AW-1:0];
      S_BN_P: d_ra = p_rd[AW-1:0];
      S_BN_D: begin
        d_we = st.mu_inf;
        d_wa = mu[AW-1:0];
        d_wd = du + DW'(1);
        q_we = st.mu_inf && q_room;
        q_wd = mu;
      end
      S_D_TOP: begin
        p_ra = v[AW-1:0];
        d_we = st.b_end;
        d_wa = u[AW-1:0];
        d_wd = DIST_INF;
      end
      S_D_POP: d_ra = k_rd[AW-1:0];
      S_D_PV: d_ra = p_rd[AW-1:0];
      S_D_MD: k_we = st.mu_next;
      S_AUG1: begin
        p_we = 1'b1; p_wa = eu[AW-1:0]; p_wd = {1'b1, vv};
      end
      S_AUG2: begin
        p_we = 1'b1; p_wa = vv[AW-1:0]; p_wd = {1'b1, eu};
        k_ra = k_m2[QAW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      S_IDLE: if (cmd.accept) begin
        q <= query_state;
        s <= '0;
      end
      S_CLR: begin
        s <= st.clr_end ? '0 : s + 17'(1);
        if (st.clr_end) begin
          head <= '0; tail <= '0; found <= 1'b0;
        end
      end
      S_BI_RD: if (!st.s_end && !st.s_ev) s <= s + 17'(1);
      S_BI_WR: begin
        s <= s + 17'(1);
        if (!pm && q_room) tail <= tail + CW'(1);
      end
      S_BQ: begin
        if (st.q_more) head <= head + CW'(1);
        else begin
          s <= '0; cnt <= '0;
        end
      end
      S_BQ_U: u <= q_rd;
      S_BQ_D: begin
        du <= d_rd; b <= '0;
      end
      S_BN: if (!st.b_end && st.v_bad) b <= b + BW'(1);
      S_BN_P: begin
        mu <= p_rd[SW-1:0];
        if (!pm) begin
          found <= 1'b1; b <= b + BW'(1);
        end
      end
      S_BN_D: begin
        b <= b + BW'(1);
        if (st.mu_inf && q_room) tail <= tail + CW'(1);
      end
      S_DO_RD: begin
        if (st.s_end) begin
          s <= '0; head <= '0; tail <= '0; found <= 1'b0;
        end else if (!st.s_ev) s <= s + 17'(1);
      end
      S_DO_CK: begin
        if (pm) s <= s + 17'(1);
        else begin
          u <= s[SW-1:0]; b <= '0; sp <= CW'(1);
        end
      end
      S_D_DU: du <= d_rd;
      S_D_TOP: begin
        if (st.b_end) begin
          sp <= sp - CW'(1);
          if (st.sp_last) s <= s + 17'(1);
        end else if (st.v_bad) b <= b + BW'(1);
      end
      S_D_POP: begin
        u <= k_rd[SW-1:0]; b <= k_rd[KW-1:SW] + BW'(1);
      end
      S_D_PV: begin
        mu <= p_rd[SW-1:0];
        if (!pm) begin
          k <= sp; eu <= u; eb <= b;
        end
      end
      S_D_MD: begin
        if (st.mu_next) begin
          u <= mu; b <= '0; sp <= sp + CW'(1); du <= d_rd;
        end else b <= b + BW'(1);
      end
      S_AUG2: begin
        k <= k - CW'(1);
        if (st.k_last) s <= s + 17'(1);
      end
      S_AUG_LD: begin
        eu <= k_rd[SW-1:0]; eb <= k_rd[KW-1:SW];
      end
      S_CN_RD: if (!st.s_end && !st.s_ev) s <= s + 17'(1);
      S_CN_CK: begin
        s <= s + 17'(1);
        if (pm) cnt <= cnt + 16'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      solved <= 1'b0;
      pcount <= '0;
    end else begin
      if (cmd.op == S_QOUT && !st.out_busy) begin
        out_valid <= 1'b1;
        has_move <= solved && (q >> MAX_BITS) == '0 && pm;
        partner_state <= (solved && (q >> MAX_BITS) == '0 && pm) ? p_rd[SW-1:0] : '0;
        match_size <= pcount;
      end else if (cmd.op == S_DONE && !st.out_busy) begin
        out_valid <= 1'b1;
        has_move <= 1'b0;
        partner_state <= '0;
        match_size <= cnt;
        pcount <= cnt;
        solved <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

/* hw/rtl/hypercube_bipartite_matcher_core.sv */
// channel   handshake            payload
// in        in_valid / in_stall  cmd, query_state
// out       out_valid / out_stall partner_state, has_move, match_size
// cfg       APB write/read       num_bulbs @0x0, max_on @0x4
//
// A query does one partner memory read, then loads the result register.
// A solve first clears the partner memory, then runs BFS and DFS phases until
// a BFS finds no free state, and then counts the matched pairs.
// Sync reset clears the controller, the output valid, the solved flag and the pair count.
// A new request is taken only while idle; a finished request waits for the
// result register while the previous result is still stalled.
module hypercube_bipartite_matcher_core #(
  parameter int MAX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] query_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] partner_state,
  output logic        has_move,
  output logic [15:0] match_size,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hbm_pkg::*;

  logic [4:0] num_bulbs, max_on;
  ctrl_cmd_t ccmd;
  stat_t st;

  assign pready = 1'b1;
  assign prdata = {27'b0, paddr[2] ? max_on : num_bulbs};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bulbs <= 5'd16;
      max_on <= 5'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) max_on <= pwdata[4:0];
      else num_bulbs <= pwdata[4:0];
    end
  end

  hbm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_cmd(cmd), .in_stall, .st, .cmd(ccmd)
  );

  hbm_datapath #(.MAX_BITS(MAX_BITS)) u_dp (
    .clk, .rst, .cmd(ccmd), .st, .num_bulbs, .max_on, .query_state,
    .out_stall, .out_valid, .partner_state, .has_move, .match_size
  );
endmodule
